@@ src/lrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg: shared types and constants
// Generator constants, the queued request record and the back-end states.
// ----------------------------------------------------------------------------
package lrr_pkg;

    localparam int STATE_W = 31;
    localparam int SPAN_W  = STATE_W + 1;

    localparam logic [14:0]        LCG_MULT   = 15'd16807;
    localparam logic [STATE_W-1:0] LCG_MOD    = 31'h7fff_ffff;
    localparam logic [STATE_W-1:0] SEED_RESET = 31'd123456;

    typedef struct packed {
        logic [STATE_W-1:0] low;
        logic [STATE_W-1:0] high;
        logic [STATE_W-1:0] state;
        logic [SPAN_W-1:0]  span;
        logic               empty;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM
    } t_back_state;

endpackage

@@ src/lrr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_fifo: request queue
// Short first-in first-out queue between the generator front end and the
// range-reduction back end.
// ----------------------------------------------------------------------------
module lrr_fifo #(
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lrr_pkg::t_item i_item,
    input  logic           i_pop,
    output lrr_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty,
    output logic [CW-1:0]  o_count
);
    import lrr_pkg::*;

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ src/lrr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_front: generator front end
// Accepts requests, advances the minimal standard generator state, sizes the
// interval and queues the request for range reduction.
// ----------------------------------------------------------------------------
module lrr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [lrr_pkg::STATE_W-1:0]  i_cfg_seed,
    input  logic                         i_in_valid,
    input  logic [lrr_pkg::STATE_W-1:0]  i_range_low,
    input  logic [lrr_pkg::STATE_W-1:0]  i_range_high,
    input  logic                         i_full,
    output logic                         o_push,
    output lrr_pkg::t_item               o_item
);
    import lrr_pkg::*;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [29:0]        w_hi;
    logic [30:0]        w_lo;
    logic [29:0]        w_hi1;
    logic [16:0]        w_lo2;
    logic [SPAN_W-1:0]  w_t;

    always_comb begin
        w_hi  = 30'(LCG_MULT) * 30'(r_state[30:16]);
        w_lo  = 31'(LCG_MULT) * 31'(r_state[15:0]);
        w_hi1 = w_hi + 30'(w_lo[30:16]);
        w_lo2 = 17'(w_lo[15:0]) + 17'(w_hi1[29:15]);
        w_t   = {1'b0, w_hi1[14:0], 16'b0} + SPAN_W'(w_lo2);
        if (w_t >= SPAN_W'(LCG_MOD)) begin
            n_state = STATE_W'(w_t - SPAN_W'(LCG_MOD));
        end else begin
            n_state = w_t[STATE_W-1:0];
        end
    end

    assign o_push = i_in_valid && !i_full;

    always_comb begin
        o_item.low   = i_range_low;
        o_item.high  = i_range_high;
        o_item.state = n_state;
        o_item.span  = SPAN_W'(i_range_high) - SPAN_W'(i_range_low) + 1'b1;
        o_item.empty = (i_range_high <= i_range_low);
    end

    // reload on seed write, else advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_state <= i_cfg_seed;
        end else if (o_push) begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/lrr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_back: range-reduction back end
// Takes queued requests, reduces the generator state modulo the interval
// size one bit per cycle, adds the low bound (high bound if empty) and holds the result.
// ----------------------------------------------------------------------------
module lrr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  lrr_pkg::t_item               i_item,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lrr_pkg::STATE_W-1:0]  o_value,
    output logic [lrr_pkg::STATE_W-1:0]  o_raw_state
);
    import lrr_pkg::*;

    localparam int BW = $clog2(STATE_W);

    t_back_state        r_st;
    t_back_state        n_st;
    t_item              r_item;
    logic [STATE_W-1:0] r_rem;
    logic [STATE_W-1:0] r_dvd;
    logic [BW-1:0]      r_cnt;
    logic               r_out_valid;
    logic [STATE_W-1:0] r_value;
    logic [STATE_W-1:0] r_raw;
    logic               w_load;
    logic               w_step;
    logic               w_emit;
    logic               w_free;
    logic [SPAN_W-1:0]  w_sh;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign w_sh        = {r_rem, r_dvd[STATE_W-1]};
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_raw_state = r_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        n_st   = r_st;
        o_pop  = 1'b0;
        w_load = 1'b0;
        w_step = 1'b0;
        w_emit = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop  = 1'b1;
                    w_load = 1'b1;
                    n_st   = i_item.empty ? ST_SUM : ST_DIV;
                end
            end
            ST_DIV: begin
                w_step = 1'b1;
                if (r_cnt == '0) begin
                    n_st = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_free) begin
                    w_emit = 1'b1;
                    n_st   = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
            r_dvd  <= i_item.state;
            r_rem  <= '0;
            r_cnt  <= BW'(STATE_W - 1);
        end else if (w_step) begin
            r_dvd <= {r_dvd[STATE_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (w_sh >= r_item.span) begin
                r_rem <= STATE_W'(w_sh - r_item.span);
            end else begin
                r_rem <= w_sh[STATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_raw   <= r_item.state;
            r_value <= r_item.empty ? r_item.high : r_item.low + r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

@@ src/lehmer_random_in_range.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lehmer_random_in_range: minimal standard generator with range reduction
// Advances a 31-bit state by 16807 modulo 2^31-1 per request and returns
// low + state mod (high - low + 1), or high for an empty interval.
//
//   channel   dir   handshake                  payload
//   cfg       in    i_cfg_valid / o_cfg_ready  i_cfg_seed
//   request   in    i_in_valid / o_in_stall    i_range_low, i_range_high
//   result    out   o_out_valid / i_out_stall  o_value, o_raw_state
//
// In the back end a request passes through load, 31 remainder steps and sum,
// or load and sum only for an empty interval; the bit-serial remainder loop sets the rate.
// The front end advances the state in the accept cycle and queues up to
// QUEUE_DEPTH requests, so requests are taken while the back end works.
// Reset loads the state with 123456 and empties the queue and result.
// A stalled result holds; the back end waits in its sum step until it drains.
// ----------------------------------------------------------------------------
module lehmer_random_in_range #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lrr_pkg::STATE_W-1:0]  i_cfg_seed,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lrr_pkg::STATE_W-1:0]  i_range_low,
    input  logic [lrr_pkg::STATE_W-1:0]  i_range_high,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lrr_pkg::STATE_W-1:0]  o_value,
    output logic [lrr_pkg::STATE_W-1:0]  o_raw_state
);
    import lrr_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          w_push_item;
    t_item          w_pop_item;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    logic [CW-1:0]  w_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;

    lrr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_seed   (i_cfg_seed),
        .i_in_valid   (i_in_valid),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    lrr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    lrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_item      (w_pop_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_raw_state (o_raw_state)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(QUEUE_DEPTH))
        else $error("request queue count exceeds depth");

    a_state_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_raw_state != LCG_MOD))
        else $error("generator state not reduced modulo 2^31-1");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && w_count == '0))
        else $error("reset left a result or queued request");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("back end popped an empty queue");

endmodule

@@ verif/tb_lehmer_random_in_range.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lehmer_random_in_range: self-checking bench for the range generator
// Feeds bound pairs through a queued driver under random request gaps and
// result stalls, tracks the 16807 generator state on its own and checks
// each returned value and raw state in order. Seeds, including zero and the
// out-of-range all-ones value, are reloaded between phases while idle.
// ----------------------------------------------------------------------------
module tb_lehmer_random_in_range;

    import lrr_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          HOLD_AT     = 300;
    localparam int          HOLD_LEN    = 400;
    localparam int          SETTLE      = 40;
    localparam logic [30:0] FIELD_MAX   = 31'h7fff_ffff;

    typedef struct {
        logic [STATE_W-1:0] low;
        logic [STATE_W-1:0] high;
    } bounds_t;

    typedef struct {
        logic [STATE_W-1:0] value;
        logic [STATE_W-1:0] raw_state;
    } draw_t;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [STATE_W-1:0] i_cfg_seed   = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [STATE_W-1:0] i_range_low  = '0;
    logic [STATE_W-1:0] i_range_high = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [STATE_W-1:0] o_value;
    logic [STATE_W-1:0] o_raw_state;

    bounds_t            pending_bounds[$];
    draw_t              expected_draws[$];
    logic [STATE_W-1:0] lehmer_state   = SEED_RESET;
    logic               no_idle        = 1'b0;
    logic               hold_done      = 1'b0;
    int                 gap_left       = 0;
    int                 stall_left     = 0;
    int                 requests_taken = 0;
    int                 draws_checked  = 0;
    int                 seeds_written  = 0;
    int                 fail_count     = 0;

    lehmer_random_in_range i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_seed   (i_cfg_seed),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_raw_state  (o_raw_state)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [STATE_W-1:0] lehmer_next(input logic [STATE_W-1:0] s);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] t;
        hi = 64'(LCG_MULT) * 64'(s[30:16]);
        lo = 64'(LCG_MULT) * 64'(s[15:0]);
        hi = hi + (lo >> 16);
        lo = lo & 64'hffff;
        lo = lo + (hi >> 15);
        hi = hi & 64'h7fff;
        t  = (hi << 16) + lo;
        if (t >= 64'(LCG_MOD)) begin
            t = t - 64'(LCG_MOD);
        end
        return t[30:0];
    endfunction

    task automatic predict_draw(input logic [STATE_W-1:0] low, input logic [STATE_W-1:0] high);
        draw_t       d;
        logic [63:0] span;
        lehmer_state = lehmer_next(lehmer_state);
        d.raw_state  = lehmer_state;
        if (high <= low) begin
            d.value = high;
        end else begin
            span    = 64'(high) - 64'(low) + 64'd1;
            d.value = 31'(64'(low) + (64'(lehmer_state) % span));
        end
        expected_draws.push_back(d);
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_bounds(input logic [STATE_W-1:0] low, input logic [STATE_W-1:0] high);
        bounds_t b;
        b.low  = low;
        b.high = high;
        pending_bounds.push_back(b);
    endtask

    task automatic queue_random_bounds();
        logic [STATE_W-1:0] a;
        logic [STATE_W-1:0] b;
        logic [63:0]        sp;
        int                 r;
        r = $urandom_range(0, 99);
        a = 31'($urandom());
        b = 31'($urandom());
        if (r < 55) begin
            sp = 64'($urandom()) & ((64'd1 << $urandom_range(0, 30)) - 64'd1);
            if (64'(a) + sp > 64'(FIELD_MAX)) begin
                a = 31'(64'(FIELD_MAX) - sp);
            end
            queue_bounds(a, a + sp[30:0]);
        end else if (r < 75) begin
            queue_bounds(a, b);
        end else if (r < 87) begin
            queue_bounds((a > b) ? a : b, (a > b) ? b : a);
        end else begin
            queue_bounds($urandom_range(0, 1) ? 31'd0 : a,
                         $urandom_range(0, 1) ? FIELD_MAX : FIELD_MAX - 31'd1);
        end
    endtask

    task automatic write_seed(input logic [STATE_W-1:0] seed);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        lehmer_state  = seed;
        seeds_written = seeds_written + 1;
    endtask

    task automatic drain();
        while (pending_bounds.size() != 0 || i_in_valid || expected_draws.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        bounds_t b;
        logic    taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                predict_draw(i_range_low, i_range_high);
                requests_taken = requests_taken + 1;
            end
            if (!i_in_valid || taken) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_bounds.size() != 0) begin
                    b = pending_bounds.pop_front();
                    i_range_low  <= b.low;
                    i_range_high <= b.high;
                    i_in_valid   <= 1'b1;
                    gap_left     <= no_idle ? 0 : pick_idle();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall, with one long hold once HOLD_AT requests have been taken
    always @(posedge i_clk) begin
        int n;
        if (!hold_done && requests_taken >= HOLD_AT) begin
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
            stall_left  <= HOLD_LEN - 1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            n = pick_idle();
            i_out_stall <= (n != 0);
            stall_left  <= (n != 0) ? n - 1 : 0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        draw_t d;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result: value %0d raw_state %0d", o_value, o_raw_state);
                fail_count = fail_count + 1;
            end else begin
                d = expected_draws.pop_front();
                draws_checked = draws_checked + 1;
                if (o_value !== d.value) begin
                    $error("value: expected %0d, got %0d", d.value, o_value);
                    fail_count = fail_count + 1;
                end
                if (o_raw_state !== d.raw_state) begin
                    $error("raw_state: expected %0d, got %0d", d.raw_state, o_raw_state);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("tb_lehmer_random_in_range: FAIL");
        $finish;
    end

    initial begin
        logic [STATE_W-1:0] seeds[7];
        seeds[0] = '0;
        seeds[1] = FIELD_MAX;
        seeds[2] = 31'd1;
        seeds[3] = FIELD_MAX - 31'd1;
        for (int i = 4; i < 7; i++) begin
            seeds[i] = 31'($urandom_range(1, 32'h7fff_fffe));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bound extremes under the reset seed
        queue_bounds(31'd0, 31'd0);
        queue_bounds(31'd0, FIELD_MAX);
        queue_bounds(FIELD_MAX, FIELD_MAX);
        queue_bounds(FIELD_MAX, 31'd0);
        queue_bounds(31'd5, 31'd5);
        queue_bounds(31'd0, 31'd1);
        queue_bounds(31'd100, 31'd200);
        queue_bounds(FIELD_MAX - 31'd1, FIELD_MAX);
        queue_bounds(31'h4000_0000, 31'h3fff_ffff);
        queue_bounds(31'h2aaa_aaaa, 31'h5555_5555);
        queue_bounds(31'h5555_5555, 31'h2aaa_aaaa);
        queue_bounds(31'd1, FIELD_MAX);
        queue_bounds(31'd0, FIELD_MAX - 31'd1);
        queue_bounds(31'd7, 31'd6);
        queue_bounds(31'd0, 31'd2);
        queue_bounds(31'h3fff_ffff, 31'h4000_0000);
        queue_bounds(31'd12345, 31'd12345 + 31'hffff);
        queue_bounds(31'd0, 31'h0000_ffff);
        queue_bounds(31'h7fff_0000, FIELD_MAX);
        queue_bounds(31'd0, 31'h4000_0000);
        drain();

        for (int p = 0; p < 7; p++) begin
            no_idle <= (p == 5);
            write_seed(seeds[p]);
            if (p < 2) begin
                queue_bounds(31'd0, FIELD_MAX);
                queue_bounds(FIELD_MAX, 31'd3);
                for (int k = 0; k < 13; k++) begin
                    queue_random_bounds();
                end
            end else begin
                for (int k = 0; k < 215; k++) begin
                    queue_random_bounds();
                end
            end
            drain();
        end

        $display("covered %0d requests, %0d results checked, %0d seed loads",
                 requests_taken, draws_checked, seeds_written);
        $display("seeds include zero, all ones and both range ends; one long result hold");
        if (fail_count == 0) begin
            $display("tb_lehmer_random_in_range: PASS");
        end else begin
            $display("tb_lehmer_random_in_range: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lrr_pkg.sv
src/lrr_fifo.sv
src/lrr_front.sv
src/lrr_back.sv
src/lehmer_random_in_range.sv
verif/tb_lehmer_random_in_range.sv
